[hdl/a2s_pkg.sv]
// ----------------------------------------------------------------------------
// a2s_pkg: shared types and constants for the ASCII to scan-code encoder
// Holds the key lookup table, the scan-code constants and the sequence
// word passed from the decode stage to the emitter.
// ----------------------------------------------------------------------------
package a2s_pkg;

    localparam logic [1:0] KIND_SCAN     = 2'd0;
    localparam logic [1:0] KIND_EXIT     = 2'd1;
    localparam logic [1:0] KIND_UNMAPPED = 2'd2;

    localparam logic [7:0] SC_LSHIFT = 8'h2A;
    localparam logic [7:0] SC_BREAK  = 8'h80;
    localparam logic [7:0] SC_F10    = 8'h44;
    localparam logic [7:0] SC_LCTRL  = 8'h1D;
    localparam logic [7:0] SC_KEY_C  = 8'h2E;
    localparam logic [7:0] SC_MASK   = 8'h7F;

    localparam logic [7:0] KEY_EXIT  = 8'h5C;
    localparam logic [7:0] KEY_F10   = 8'h60;
    localparam logic [7:0] KEY_CTRLC = 8'h7E;

    // Bit 7 flags a shifted key, bits 6..0 hold the make code, zero is unmapped.
    localparam logic [7:0] KEY_MAP [0:127] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0E,
        8'h0E, 8'h0F, 8'h1C, 8'h00, 8'h00, 8'h1C, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h39, 8'h82, 8'hA8, 8'h84, 8'h85, 8'h86, 8'h88, 8'h28,
        8'h8A, 8'h8B, 8'h89, 8'h8D, 8'h33, 8'h0C, 8'h34, 8'h35,
        8'h0B, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
        8'h09, 8'h0A, 8'hA7, 8'h27, 8'hB3, 8'h0D, 8'hB4, 8'hB5,
        8'h83, 8'h9E, 8'hB0, 8'hAE, 8'hA0, 8'h92, 8'hA1, 8'hA2,
        8'hA3, 8'h97, 8'hA4, 8'hA5, 8'hA6, 8'hB2, 8'hB1, 8'h98,
        8'h99, 8'h90, 8'h93, 8'h9F, 8'h94, 8'h96, 8'hAF, 8'h91,
        8'hAD, 8'h95, 8'hAC, 8'h1A, 8'h2B, 8'h1B, 8'h87, 8'h8C,
        8'h29, 8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22,
        8'h23, 8'h17, 8'h24, 8'h25, 8'h26, 8'h32, 8'h31, 8'h18,
        8'h19, 8'h10, 8'h13, 8'h1F, 8'h14, 8'h16, 8'h2F, 8'h11,
        8'h2D, 8'h15, 8'h2C, 8'h9A, 8'hAB, 8'h9B, 8'hA9, 8'h0E
    };

    // Up to four codes for one key; last_idx is the index of the final one.
    typedef struct packed {
        logic [3:0][7:0] codes;
        logic [1:0]      last_idx;
        logic [1:0]      kind;
    } seq_t;

endpackage

[hdl/a2s_emitter.sv]
// ----------------------------------------------------------------------------
// a2s_emitter: scan-code sequence emitter
// Holds one key's decoded sequence and sends one word per cycle while
// out_ready is high, loading the next key in the cycle its last word is taken.
// ----------------------------------------------------------------------------
module a2s_emitter
    import a2s_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load_valid,
    input  seq_t       load_seq,
    output logic       load_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] code_byte,
    output logic [1:0] kind,
    output logic       last
);

    logic       busy_reg;
    logic [1:0] idx_reg;
    seq_t       seq_reg;
    logic       done;
    logic       take;

    assign last       = (idx_reg == seq_reg.last_idx);
    assign done       = busy_reg && out_ready && last;
    assign load_ready = !busy_reg || done;
    assign take       = load_valid && load_ready;

    assign out_valid = busy_reg;
    assign code_byte = seq_reg.codes[idx_reg];
    assign kind      = seq_reg.kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (take)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg && out_ready)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            seq_reg <= load_seq;
        end
    end

endmodule

[hdl/ascii_to_scancode_encoder.sv]
// ----------------------------------------------------------------------------
// ascii_to_scancode_encoder: typed key byte to scan-code set 1 sequence
// Looks each key up in a 128-entry ROM and emits its make/break sequence, or one exit or unmapped word.
//
//   Channel  Signals                        Direction  Word
//   in       in_valid, in_ready, key_byte   input      one typed key
//   out      out_valid, out_ready,          output     one scan code result
//            code_byte, kind, last
//
// A key producing n results (1 to 4) sends them one after another on the
// single output port of the emitter, which sets the rate; a shifted key gives four.
// The first result passes the ROM read register, then the emitter, which may still be busy.
// A new key is taken while the previous sequence is still being sent.
// Reset clears only the valid flags and the emitter's word index; the ROM needs no clearing pass.
// ----------------------------------------------------------------------------
module ascii_to_scancode_encoder
    import a2s_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] key_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] code_byte,
    output logic [1:0] kind,
    output logic       last
);

    logic       a_valid_reg;
    logic [7:0] a_key_reg;
    logic [7:0] a_entry_reg;
    logic       load_ready;
    logic       in_take;
    seq_t       dec_seq;
    logic [7:0] make;

    assign in_ready = !a_valid_reg || load_ready;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (load_ready)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    // Synchronous ROM read, registered together with the key.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_key_reg   <= key_byte;
            a_entry_reg <= KEY_MAP[key_byte[6:0]];
        end
    end

    assign make = a_entry_reg & SC_MASK;

    always_comb
    begin
        dec_seq          = '0;
        dec_seq.kind     = KIND_SCAN;
        dec_seq.last_idx = 2'd0;
        if (a_key_reg == KEY_EXIT)
        begin
            dec_seq.kind = KIND_EXIT;
        end
        else if (a_key_reg == KEY_F10)
        begin
            dec_seq.codes[0] = SC_F10;
            dec_seq.codes[1] = SC_F10 | SC_BREAK;
            dec_seq.last_idx = 2'd1;
        end
        else if (a_key_reg == KEY_CTRLC)
        begin
            dec_seq.codes[0] = SC_LCTRL;
            dec_seq.codes[1] = SC_KEY_C;
            dec_seq.codes[2] = SC_KEY_C | SC_BREAK;
            dec_seq.codes[3] = SC_LCTRL | SC_BREAK;
            dec_seq.last_idx = 2'd3;
        end
        else if (a_key_reg[7] || (a_entry_reg == 8'h00))
        begin
            dec_seq.kind = KIND_UNMAPPED;
        end
        else if (a_entry_reg[7])
        begin
            dec_seq.codes[0] = SC_LSHIFT;
            dec_seq.codes[1] = make;
            dec_seq.codes[2] = make | SC_BREAK;
            dec_seq.codes[3] = SC_LSHIFT | SC_BREAK;
            dec_seq.last_idx = 2'd3;
        end
        else
        begin
            dec_seq.codes[0] = make;
            dec_seq.codes[1] = make | SC_BREAK;
            dec_seq.last_idx = 2'd1;
        end
    end

    a2s_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (a_valid_reg),
        .load_seq   (dec_seq),
        .load_ready (load_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_byte  (code_byte),
        .kind       (kind),
        .last       (last)
    );

    // Exit and unmapped results are single words with a zero code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_SCAN) |-> last && (code_byte == 8'h00))
        else $error("non-scan result is not a single zero word");

    // An accepted key always lands in the lookup stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> a_valid_reg)
        else $error("accepted key lost before lookup");

    // Input is refused only while a looked-up key waits for the emitter.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> a_valid_reg && out_valid)
        else $error("input stalled with nothing pending");

    // The final word of a sequence being taken frees the emitter for a waiting key.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last && a_valid_reg |=> out_valid)
        else $error("pending key not loaded after sequence end");

endmodule

[bench/ascii_to_scancode_encoder_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascii_to_scancode_encoder_test: self-checking bench for the scan-code encoder
// Feeds typed key bytes through the input channel and predicts the set 1
// make/break sequence for each accepted key.  Every result word leaving the
// block is compared in order against the prediction, with random stalls on both channels.
// ----------------------------------------------------------------------------
module ascii_to_scancode_encoder_test;
    import a2s_pkg::*;

    typedef struct packed {
        logic [7:0] code;
        logic [1:0] kind;
        logic       last;
    } scan_word_t;

    // Bit 7 marks a key typed with shift, bits 6..0 give the make code.
    localparam logic [7:0] KEYCAP_TABLE [0:127] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0E,
        8'h0E, 8'h0F, 8'h1C, 8'h00, 8'h00, 8'h1C, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h39, 8'h82, 8'hA8, 8'h84, 8'h85, 8'h86, 8'h88, 8'h28,
        8'h8A, 8'h8B, 8'h89, 8'h8D, 8'h33, 8'h0C, 8'h34, 8'h35,
        8'h0B, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
        8'h09, 8'h0A, 8'hA7, 8'h27, 8'hB3, 8'h0D, 8'hB4, 8'hB5,
        8'h83, 8'h9E, 8'hB0, 8'hAE, 8'hA0, 8'h92, 8'hA1, 8'hA2,
        8'hA3, 8'h97, 8'hA4, 8'hA5, 8'hA6, 8'hB2, 8'hB1, 8'h98,
        8'h99, 8'h90, 8'h93, 8'h9F, 8'h94, 8'h96, 8'hAF, 8'h91,
        8'hAD, 8'h95, 8'hAC, 8'h1A, 8'h2B, 8'h1B, 8'h87, 8'h8C,
        8'h29, 8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22,
        8'h23, 8'h17, 8'h24, 8'h25, 8'h26, 8'h32, 8'h31, 8'h18,
        8'h19, 8'h10, 8'h13, 8'h1F, 8'h14, 8'h16, 8'h2F, 8'h11,
        8'h2D, 8'h15, 8'h2C, 8'h9A, 8'hAB, 8'h9B, 8'hA9, 8'h0E
    };

    // Extremes, the three special keys, shifted and plain keys, unmapped codes.
    localparam logic [7:0] DIRECTED_KEYS [0:19] = '{
        8'h00, 8'hFF, 8'h80, 8'h7F, KEY_EXIT, KEY_F10, KEY_CTRLC, 8'h41,
        8'h61, 8'h20, 8'h01, 8'h1B, 8'h22, 8'h7C, 8'h55, 8'hAA,
        8'h0A, 8'h09, 8'h30, 8'h7D
    };

    localparam int RX_HOLD_CYCLES = 64;
    localparam int SETTLE_CYCLES  = 8;

    class scancode_tracker;
        scan_word_t expected_words[$];
        int         mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_key(logic [7:0] key);
            logic [7:0] seq [4];
            logic [7:0] entry;
            logic [7:0] make;
            int         n;
            n = 0;
            entry = KEYCAP_TABLE[key[6:0]];
            make = entry & SC_MASK;
            if (key == KEY_EXIT)
            begin
                expected_words.push_back({8'h00, KIND_EXIT, 1'b1});
            end
            else if (key == KEY_F10)
            begin
                seq[0] = SC_F10;
                seq[1] = SC_F10 | SC_BREAK;
                n = 2;
            end
            else if (key == KEY_CTRLC)
            begin
                seq[0] = SC_LCTRL;
                seq[1] = SC_KEY_C;
                seq[2] = SC_KEY_C | SC_BREAK;
                seq[3] = SC_LCTRL | SC_BREAK;
                n = 4;
            end
            else if (key[7] || entry == 8'h00)
            begin
                expected_words.push_back({8'h00, KIND_UNMAPPED, 1'b1});
            end
            else
            begin
                if (entry[7])
                begin
                    seq[n] = SC_LSHIFT;
                    n++;
                end
                seq[n] = make;
                seq[n + 1] = make | SC_BREAK;
                n += 2;
                if (entry[7])
                begin
                    seq[n] = SC_LSHIFT | SC_BREAK;
                    n++;
                end
            end
            for (int i = 0; i < n; i++)
                expected_words.push_back({seq[i], KIND_SCAN, 1'(i == n - 1)});
        endfunction

        function void check_result(logic [7:0] got_code, logic [1:0] got_kind,
                                   logic got_last);
            scan_word_t want;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected word code %h kind %0d last %b",
                             $time, got_code, got_kind, got_last);
                return;
            end
            want = expected_words.pop_front();
            if (want.code !== got_code || want.kind !== got_kind || want.last !== got_last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: expected code %h kind %0d last %b, ",
                              "got code %h kind %0d last %b"},
                             $time, want.code, want.kind, want.last,
                             got_code, got_kind, got_last);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] key_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] code_byte;
    logic [1:0] kind;
    logic       last;

    int send_idle_pct;
    int recv_idle_pct;
    bit rx_hold_request;

    scancode_tracker tracker = new();

    ascii_to_scancode_encoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .key_byte  (key_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .code_byte (code_byte),
        .kind      (kind),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("ascii_to_scancode_encoder verification failed");
        $finish;
    end

    // Present one key and hold it until the block takes the word.
    task automatic offer_key(input logic [7:0] key);
        @(negedge clk);
        in_valid <= 1'b1;
        key_byte <= key;
        do @(posedge clk); while (!in_ready);
        tracker.note_key(key);
    endtask

    task automatic key_gap();
        int gap;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            in_valid <= 1'b0;
            key_byte <= 8'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_random_key();
        int         pick;
        logic [7:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            key = 8'($urandom_range(8'h20, 8'h7E));
        else if (pick < 60)
        begin
            case ($urandom_range(0, 2))
                0:       key = KEY_EXIT;
                1:       key = KEY_F10;
                default: key = KEY_CTRLC;
            endcase
        end
        else if (pick < 80)
            key = 8'($urandom_range(0, 127));
        else
            key = 8'($urandom_range(0, 255));
        offer_key(key);
        key_gap();
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.expected_words.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, or one long hold-off when the stimulus asks for it.
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_hold_request)
            begin
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                rx_hold_request = 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result(code_byte, kind, last);
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        key_byte = 8'h00;
        send_idle_pct = 29;
        recv_idle_pct = 76;
        rx_hold_request = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_KEYS[i])
        begin
            offer_key(DIRECTED_KEYS[i]);
            key_gap();
        end
        repeat (150) send_random_key();
        drain_results();

        send_idle_pct = 76;
        recv_idle_pct = 29;
        repeat (150) send_random_key();

        // Shifted keys back to back while the output is held off fill the block.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rx_hold_request = 1'b1;
        repeat (30) offer_key(8'($urandom_range(8'h41, 8'h5A)));
        repeat (150) send_random_key();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.expected_words.size() == 0)
            $display("ascii_to_scancode_encoder verification clean");
        else
            $display("ascii_to_scancode_encoder verification failed");
        $finish;
    end

endmodule

[ascii_to_scancode_encoder.f]
hdl/a2s_pkg.sv
hdl/a2s_emitter.sv
hdl/ascii_to_scancode_encoder.sv
bench/ascii_to_scancode_encoder_test.sv
